// ===== rtl/stereo_chorus_assert.svh =====
// Assertion macros shared by the stereo chorus RTL.
`ifndef STEREO_CHORUS_ASSERT_SVH
`define STEREO_CHORUS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stereo_chorus check failed");

// Next-cycle implication, checked outside reset.
`define SC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stereo_chorus check failed");

`endif

// ===== rtl/sc_pkg.sv =====
// Types, constants and the sine table of the stereo chorus.
`timescale 1ns / 1ps
package sc_pkg;

   localparam int ADDR_BITS    = 12;
   localparam int LINE_LENGTH  = 1 << ADDR_BITS;
   localparam int SINE_BITS    = 10;
   localparam int SINE_ENTRIES = 1 << SINE_BITS;
   localparam int FRAC_BITS    = 23;
   localparam int POS_BITS     = ADDR_BITS + FRAC_BITS;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef enum logic [2:0] {
      REG_DEPTH_A      = 3'd0,
      REG_DEPTH_B      = 3'd1,
      REG_BASE_DELAY_A = 3'd2,
      REG_BASE_DELAY_B = 3'd3,
      REG_PHASE_STEP_A = 3'd4,
      REG_PHASE_STEP_B = 3'd5,
      REG_START_PHASES = 3'd6,
      REG_MIX          = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] left_in;
      logic signed [31:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_out;
      logic signed [31:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] depth_a;
      logic [15:0] depth_b;
      logic [11:0] base_delay_a;
      logic [11:0] base_delay_b;
      logic [16:0] mix;
      logic [31:0] phase_left;
      logic [31:0] phase_right;
   } cfg_type;

   typedef logic signed [15:0] sine_tab_type [SINE_ENTRIES];

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      longint t, quad, u, x, x2, term, sum, q;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         t    = (longint'(k) << 32) / SINE_ENTRIES;
         quad = t >>> 30;
         u    = t & 64'sh3FFF_FFFF;
         if (quad[0]) begin
            u = 64'sd1073741824 - u;
         end
         x    = (u * HALF_PI_Q30) >>> 30;
         x2   = (x * x) >>> 30;
         sum  = x;
         term = ((x * x2) >>> 30) / 6;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >>> 30) / 42;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 72;
         sum  = sum + term;
         term = ((term * x2) >>> 30) / 110;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 156;
         sum  = sum + term;
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + 16384) >>> 15;
         if (q > 32767) begin
            q = 32767;
         end
         tab[k] = (quad >= 2) ? 16'(-q) : 16'(q);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

// ===== rtl/sc_core.sv =====
// Sequencer, delay lines and shared multiplier of the stereo chorus.
`timescale 1ns / 1ps
module sc_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  sc_pkg::req_type in_data,
   input  sc_pkg::cfg_type cfg,
   output logic            idle,
   output logic            done,
   output sc_pkg::rsp_type out_data
);
   import sc_pkg::*;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_WRITE  = 11'b00000000100,
      ST_POS    = 11'b00000001000,
      ST_RD1    = 11'b00000010000,
      ST_RD2    = 11'b00000100000,
      ST_INTERP = 11'b00001000000,
      ST_WET    = 11'b00010000000,
      ST_MIX1   = 11'b00100000000,
      ST_MIX2   = 11'b01000000000,
      ST_SAT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic                 ch_ff;
   logic [ADDR_BITS-1:0] clr_ff;
   logic [ADDR_BITS-1:0] head_ff;
   req_type              in_ff;
   logic [ADDR_BITS-1:0] i1_ff;
   logic [15:0]          frac_ff;
   logic signed [31:0]   s1_ff;
   logic signed [31:0]   wet_ff;
   logic signed [51:0]   prod_ff, prod_in;
   logic signed [52:0]   acc_ff;
   logic signed [31:0]   left_ff;

   logic signed [31:0] line_l [LINE_LENGTH];
   logic signed [31:0] line_r [LINE_LENGTH];
   logic signed [31:0] rd_l_ff, rd_r_ff;

   logic signed [31:0]   in_val, rd_val, sat_val;
   logic [15:0]          depth;
   logic [11:0]          base;
   logic [31:0]          phase;
   logic signed [15:0]   sine_val;
   logic [16:0]          gain;
   logic signed [33:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic [POS_BITS-1:0]  delay, pos;
   logic signed [36:0]   shifted;
   logic                 we_l, we_r;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic signed [31:0]   wr_data;

   assign in_val   = ch_ff ? in_ff.right_in : in_ff.left_in;
   assign rd_val   = ch_ff ? rd_r_ff : rd_l_ff;
   assign depth    = ch_ff ? cfg.depth_b : cfg.depth_a;
   assign base     = ch_ff ? cfg.base_delay_b : cfg.base_delay_a;
   assign phase    = ch_ff ? cfg.phase_right : cfg.phase_left;
   assign sine_val = SINE_TAB[phase[31 -: SINE_BITS]];
   assign gain     = (cfg.mix > 17'd65536) ? 17'd65536 : cfg.mix;

   assign delay = {base, {FRAC_BITS{1'b0}}} + prod_ff[POS_BITS-1:0];
   assign pos   = {head_ff, {FRAC_BITS{1'b0}}} - delay;
   assign shifted = acc_ff[52:16];

   always_comb begin
      if (shifted > 37'sd2147483647) begin
         sat_val = 32'sd2147483647;
      end else if (shifted < -37'sd2147483647) begin
         sat_val = -32'sd2147483647;
      end else begin
         sat_val = shifted[31:0];
      end
   end

   always_comb begin
      case (state_ff)
         ST_WRITE: begin
            mul_a = 34'(sine_val);
            mul_b = signed'({2'b00, depth});
         end
         ST_INTERP: begin
            mul_a = 34'(rd_val) - 34'(s1_ff);
            mul_b = signed'({2'b00, frac_ff});
         end
         ST_MIX1: begin
            mul_a = 34'(wet_ff);
            mul_b = signed'({1'b0, gain});
         end
         default: begin
            mul_a = 34'(in_val);
            mul_b = signed'({1'b0, 17'd65536 - gain});
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign we_l    = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && !ch_ff);
   assign we_r    = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && ch_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : head_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? 32'sd0 : in_val;
   assign rd_addr = (state_ff == ST_RD2) ? i1_ff + 1'b1 : i1_ff;

   always_ff @(posedge clock) begin
      if (we_l) begin
         line_l[wr_addr] <= wr_data;
      end
      rd_l_ff <= line_l[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we_r) begin
         line_r[wr_addr] <= wr_data;
      end
      rd_r_ff <= line_r[rd_addr];
   end

   always_comb begin
      case (state_ff)
         ST_CLEAR:  state_in = (&clr_ff) ? ST_IDLE : ST_CLEAR;
         ST_IDLE:   state_in = start ? ST_WRITE : ST_IDLE;
         ST_WRITE:  state_in = ST_POS;
         ST_POS:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_RD2;
         ST_RD2:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_WET;
         ST_WET:    state_in = ST_MIX1;
         ST_MIX1:   state_in = ST_MIX2;
         ST_MIX2:   state_in = ST_SAT;
         ST_SAT:    state_in = ch_ff ? ST_IDLE : ST_WRITE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_SAT) begin
            ch_ff <= !ch_ff;
            if (ch_ff) begin
               head_ff <= head_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               in_ff <= in_data;
            end
         end
         ST_POS: begin
            i1_ff   <= pos[POS_BITS-1 -: ADDR_BITS];
            frac_ff <= pos[FRAC_BITS-1 -: 16];
         end
         ST_RD2:  s1_ff  <= rd_val;
         ST_WET:  wet_ff <= s1_ff + prod_ff[47:16];
         ST_MIX1: acc_ff <= 53'(prod_ff) + 53'sd32768;
         ST_MIX2: acc_ff <= acc_ff + 53'(prod_ff);
         ST_SAT: begin
            if (!ch_ff) begin
               left_ff <= sat_val;
            end
         end
         default: ;
      endcase
   end

   assign idle     = (state_ff == ST_IDLE);
   assign done     = (state_ff == ST_SAT) && ch_ff;
   assign out_data = {left_ff, sat_val};

endmodule

// ===== rtl/stereo_chorus.sv =====
// Stereo chorus top level: register port, handshakes and LFO phases.
// Each channel of a stereo pair runs nine steps on one shared multiplier
// and one read port per delay line, so a new pair is taken only once both
// channels are done and the last response has been accepted. After reset a
// clearing pass zeroes all 4096 entries of both delay lines before the first pair is taken.
`timescale 1ns / 1ps
`include "stereo_chorus_assert.svh"
module stereo_chorus (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sc_pkg::rsp_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
   import sc_pkg::*;

   logic [15:0] depth_a_ff, depth_b_ff;
   logic [11:0] base_a_ff, base_b_ff;
   logic [31:0] step_a_ff, step_b_ff, start_ff;
   logic [16:0] mix_ff;
   logic [31:0] phase_l_ff, phase_r_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   cfg_type     cfg;
   logic        core_idle, core_done, req_take, wr_en;
   rsp_type     core_out;
   reg_index_type reg_idx;

   assign reg_idx    = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_idx)
         REG_DEPTH_A:      csr_prdata = 32'(depth_a_ff);
         REG_DEPTH_B:      csr_prdata = 32'(depth_b_ff);
         REG_BASE_DELAY_A: csr_prdata = 32'(base_a_ff);
         REG_BASE_DELAY_B: csr_prdata = 32'(base_b_ff);
         REG_PHASE_STEP_A: csr_prdata = step_a_ff;
         REG_PHASE_STEP_B: csr_prdata = step_b_ff;
         REG_START_PHASES: csr_prdata = start_ff;
         REG_MIX:          csr_prdata = 32'(mix_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_a_ff <= 16'd2560;
         depth_b_ff <= 16'd2560;
         base_a_ff  <= 12'd720;
         base_b_ff  <= 12'd960;
         step_a_ff  <= 32'd134218;
         step_b_ff  <= 32'd143166;
         start_ff   <= '0;
         mix_ff     <= 17'd32768;
         phase_l_ff <= '0;
         phase_r_ff <= '0;
      end else begin
         if (core_done) begin
            phase_l_ff <= phase_l_ff + step_a_ff;
            phase_r_ff <= phase_r_ff + step_b_ff;
         end
         if (wr_en) begin
            case (reg_idx)
               REG_DEPTH_A:      depth_a_ff <= csr_pwdata[15:0];
               REG_DEPTH_B:      depth_b_ff <= csr_pwdata[15:0];
               REG_BASE_DELAY_A: base_a_ff  <= csr_pwdata[11:0];
               REG_BASE_DELAY_B: base_b_ff  <= csr_pwdata[11:0];
               REG_PHASE_STEP_A: step_a_ff  <= csr_pwdata;
               REG_PHASE_STEP_B: step_b_ff  <= csr_pwdata;
               REG_START_PHASES: begin
                  start_ff   <= csr_pwdata;
                  phase_l_ff <= {csr_pwdata[15:0], 16'd0};
                  phase_r_ff <= {csr_pwdata[31:16], 16'd0};
               end
               REG_MIX:          mix_ff <= csr_pwdata[16:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg = '{depth_a: depth_a_ff, depth_b: depth_b_ff, base_delay_a: base_a_ff,
                  base_delay_b: base_b_ff, mix: mix_ff, phase_left: phase_l_ff,
                  phase_right: phase_r_ff};

   assign req_stall = !core_idle || rsp_valid_ff;
   assign req_take  = req_valid && !req_stall;

   sc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .in_data  (req_data),
      .cfg      (cfg),
      .idle     (core_idle),
      .done     (core_done),
      .out_data (core_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= core_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SC_ASSERT_NOW(a_no_overwrite, core_done, !rsp_valid_ff)
   `SC_ASSERT_NEXT(a_busy_after_take, req_take, !core_idle)
   `SC_ASSERT_NEXT(a_drain, rsp_valid_ff && !rsp_stall, !rsp_valid_ff)

endmodule
